// ===== design/bcpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpa_pkg
// Types and codes shared by the binary convolution popcount accumulator.
// ----------------------------------------------------------------------------
package bcpa_pkg;

	localparam int SUM_W = 16;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_ACCUM = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [3:0]  lane;
		logic [4:0]  tap;
		logic [31:0] kernel_word;
		logic [31:0] plane_low;
		logic [31:0] plane_high;
		logic        final_req;
	} item_t;

	typedef struct packed {
		logic [3:0]              out_lane;
		logic signed [SUM_W-1:0] sum;
		logic                    run_end;
	} result_t;

	// per-cycle control shared by all lanes
	typedef struct packed {
		logic add_s2;   // item in stage 2 adds its term
		logic clr_s2;   // item in stage 2 closes the run
	} lane_ctrl_t;

endpackage

// ===== design/binary_conv_popcount_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_conv_popcount_accumulator
// Binarised convolution engine with 2-bit activations: LANES parallel lanes,
// each with its own kernel memory, popcount and wrapping 16-bit accumulator.
// ----------------------------------------------------------------------------
// Usage:
//  - item channel (item_valid / item_stall / item): a load request writes one
//    kernel word for (lane, tap); an accumulate request carries two activation
//    bit planes for one tap and updates every lane at once.
//  - result channel (result_valid / result_stall / result): after an
//    accumulate with final_req, LANES results follow in lane order, the last
//    one flagged by run_end; the accumulators start again from zero.
//  - Loads and plain accumulates are taken one per cycle, back to back, while item_stall is low.
//  - A final accumulate passes a three-stage pipe (kernel read, popcount,
//    accumulate); its first result is offered once the drain has captured the lane sums.
//  - item_stall rises after that acceptance and stays high until the last
//    result of the run is taken, longer while result_stall holds. The length
//    is set by the single drain shift register that serialises the lane
//    sums.
//  - Reset clears accumulators and the pipe; kernel memory holds garbage until
//    written. A stalled result simply holds on the port.
// ----------------------------------------------------------------------------
module binary_conv_popcount_accumulator #(
	parameter int LANES     = 16,
	parameter int TAPS      = 32,
	parameter int WORD_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  bcpa_pkg::item_t     item,
	output logic                result_valid,
	input  logic                result_stall,
	output bcpa_pkg::result_t   result
);

	localparam int KW    = (WORD_BITS < 32) ? WORD_BITS : 32;
	localparam int TAP_W = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int CNT_W = (LANES > 1) ? $clog2(LANES) : 1;

	logic                 accept;
	logic                 is_load;
	logic                 is_accum;
	logic                 tap_ok;
	logic                 lane_ok;
	logic [TAP_W-1:0]     tap_idx;
	logic                 add_s1;
	logic                 fin_s1;
	logic                 add_s2;
	logic                 fin_s2;
	logic [KW-1:0]        plane_low_s1;
	logic [KW-1:0]        plane_high_s1;
	logic                 drain_busy;
	bcpa_pkg::lane_ctrl_t ctrl;
	logic signed [bcpa_pkg::SUM_W-1:0] sums [LANES];

	assign item_stall = fin_s1 || fin_s2 || drain_busy;
	assign accept     = item_valid && !item_stall;
	assign is_load    = accept && (item.opcode == bcpa_pkg::OP_LOAD);
	assign is_accum   = accept && (item.opcode == bcpa_pkg::OP_ACCUM);
	assign tap_ok     = 32'(item.tap) < TAPS;
	assign lane_ok    = 32'(item.lane) < LANES;
	assign tap_idx    = TAP_W'(item.tap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_s1 <= 1'b0;
			fin_s1 <= 1'b0;
			add_s2 <= 1'b0;
			fin_s2 <= 1'b0;
		end else begin
			add_s1 <= is_accum && tap_ok;
			fin_s1 <= is_accum && item.final_req;
			add_s2 <= add_s1;
			fin_s2 <= fin_s1;
		end
	end

	always_ff @(posedge clk) begin
		plane_low_s1  <= item.plane_low[KW-1:0];
		plane_high_s1 <= item.plane_high[KW-1:0];
	end

	assign ctrl.add_s2 = add_s2;
	assign ctrl.clr_s2 = fin_s2;

	for (genvar j = 0; j < LANES; j++) begin : g_lane
		logic wr_en;
		assign wr_en = is_load && lane_ok && tap_ok && (32'(item.lane) == j);

		bcpa_lane #(
			.TAPS  (TAPS),
			.KW    (KW),
			.TAP_W (TAP_W)
		) u_lane (
			.clk           (clk),
			.arst_n        (arst_n),
			.wr_en         (wr_en),
			.wr_tap        (tap_idx),
			.wr_data       (item.kernel_word[KW-1:0]),
			.rd_tap        (tap_idx),
			.plane_low_s1  (plane_low_s1),
			.plane_high_s1 (plane_high_s1),
			.ctrl          (ctrl),
			.sum_next      (sums[j])
		);
	end

	bcpa_drain #(
		.LANES (LANES),
		.CNT_W (CNT_W)
	) u_drain (
		.clk          (clk),
		.arst_n       (arst_n),
		.capture      (fin_s2),
		.sums         (sums),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.busy         (drain_busy)
	);

endmodule

// ===== design/bcpa_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpa_lane
// One output-channel lane: kernel word memory, XOR popcount and the 16-bit
// wrapping accumulator.
// ----------------------------------------------------------------------------
module bcpa_lane #(
	parameter int TAPS  = 32,
	parameter int KW    = 32,
	parameter int TAP_W = 5
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [TAP_W-1:0]                 wr_tap,
	input  logic [KW-1:0]                    wr_data,
	input  logic [TAP_W-1:0]                 rd_tap,
	input  logic [KW-1:0]                    plane_low_s1,
	input  logic [KW-1:0]                    plane_high_s1,
	input  bcpa_pkg::lane_ctrl_t             ctrl,
	output logic signed [bcpa_pkg::SUM_W-1:0] sum_next
);

	localparam int PC_W = $clog2(KW + 1);

	// adder tree: pairs at stride 1, 2, 4 ... fold into the lower index
	function automatic logic [PC_W-1:0] popcnt(input logic [KW-1:0] v);
		logic [PC_W-1:0] t [KW];
		for (int i = 0; i < KW; i++) begin
			t[i] = PC_W'(v[i]);
		end
		for (int s = 1; s < KW; s = s * 2) begin
			for (int i = 0; i + s < KW; i = i + 2 * s) begin
				t[i] = t[i] + t[i+s];
			end
		end
		return t[0];
	endfunction

	logic [KW-1:0]   mem [TAPS];
	logic [KW-1:0]   k_s1;
	logic [PC_W-1:0] pc_k_s2;
	logic [PC_W-1:0] pc_lo_s2;
	logic [PC_W-1:0] pc_hi_s2;
	logic [bcpa_pkg::SUM_W-1:0] term;
	logic signed [bcpa_pkg::SUM_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_tap] <= wr_data;
		end
		k_s1 <= mem[rd_tap];
	end

	always_ff @(posedge clk) begin
		pc_k_s2  <= popcnt(k_s1);
		pc_lo_s2 <= popcnt(plane_low_s1 ^ k_s1);
		pc_hi_s2 <= popcnt(plane_high_s1 ^ k_s1);
	end

	// (lo - k) + 2*(hi - k), modulo 2^16
	always_comb begin
		term = (bcpa_pkg::SUM_W'(pc_lo_s2) - bcpa_pkg::SUM_W'(pc_k_s2))
			+ ((bcpa_pkg::SUM_W'(pc_hi_s2) - bcpa_pkg::SUM_W'(pc_k_s2)) << 1);
		sum_next = ctrl.add_s2 ? acc_q + $signed(term) : acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.clr_s2) begin
			acc_q <= '0;
		end else begin
			acc_q <= sum_next;
		end
	end

endmodule

// ===== design/bcpa_drain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpa_drain
// Merge stage: snapshots all lane sums at the end of a pixel and shifts them
// out one result per request, lane 0 first.
// ----------------------------------------------------------------------------
module bcpa_drain #(
	parameter int LANES = 16,
	parameter int CNT_W = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              capture,
	input  logic signed [bcpa_pkg::SUM_W-1:0] sums [LANES],
	output logic                              result_valid,
	input  logic                              result_stall,
	output bcpa_pkg::result_t                 result,
	output logic                              busy
);

	logic signed [bcpa_pkg::SUM_W-1:0] sh_q [LANES];
	logic [CNT_W-1:0]                  cnt_q;
	logic                              valid_q;
	logic                              take;
	logic                              last;

	assign take = valid_q && !result_stall;
	assign last = (32'(cnt_q) == LANES - 1);

	always_ff @(posedge clk) begin
		if (capture) begin
			sh_q <= sums;
		end else if (take) begin
			for (int i = 0; i < LANES - 1; i++) begin
				sh_q[i] <= sh_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (capture) begin
			valid_q <= 1'b1;
			cnt_q   <= '0;
		end else if (take) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign result_valid    = valid_q;
	assign busy            = valid_q;
	assign result.out_lane = 4'(cnt_q);
	assign result.sum      = sh_q[0];
	assign result.run_end  = last;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binary convolution popcount accumulator. Kernel
// loads and accumulate requests are driven over the item channel. A local
// xor/popcount model predicts each lane sum not typed into the directed table,
// and the result channel is checked in order, field by field. A short directed
// table comes first, then random pixels under three sender/receiver idle mixes,
// with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct {
		bcpa_pkg::item_t    req;
		bit                 typed;   // sums typed in below, same for all lanes
		logic signed [15:0] want;
	} row_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              item_valid   = 1'b0;
	logic              item_stall;
	bcpa_pkg::item_t   item         = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	bcpa_pkg::result_t result;

	// local copy of the kernel store and lane accumulators
	logic [31:0]        kern_mem [512];
	bit                 kern_set [512];
	logic signed [15:0] lane_acc [16];
	bcpa_pkg::result_t  run_buf  [16];
	bcpa_pkg::result_t  sums_due [$];
	int                 warm_taps [$];

	int mode      = 0;   // 0: sender 21 / receiver 64, 1: swapped, 2: no idling
	int hold_req  = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int errs      = 0;
	int sent_n    = 0;
	int results_n = 0;
	int runs_n    = 0;

	binary_conv_popcount_accumulator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #1 clk = ~clk;

	function automatic int ones32(input logic [31:0] w);
		int c;
		c = 0;
		for (int i = 0; i < 32; i++) c += w[i];
		return c;
	endfunction

	// applies one request to the local state; fills run_buf, returns its length
	function automatic int xnor_step(input bcpa_pkg::item_t r);
		logic [31:0] k;
		int ck, lo, hi;
		if (r.opcode == bcpa_pkg::OP_LOAD) begin
			kern_mem[{r.lane, r.tap}] = r.kernel_word;
			kern_set[{r.lane, r.tap}] = 1'b1;
			return 0;
		end
		for (int j = 0; j < 16; j++) begin
			k  = kern_mem[j * 32 + r.tap];
			ck = ones32(k);
			lo = ones32(r.plane_low ^ k) - ck;
			hi = ones32(r.plane_high ^ k) - ck;
			lane_acc[j] = lane_acc[j] + 16'(lo + 2 * hi);
		end
		if (!r.final_req)
			return 0;
		for (int j = 0; j < 16; j++) begin
			run_buf[j].out_lane = 4'(j);
			run_buf[j].sum      = lane_acc[j];
			run_buf[j].run_end  = (j == 15);
			lane_acc[j]         = '0;
		end
		return 16;
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 32'd1 << $urandom_range(0, 31);
			3: return ~(32'd1 << $urandom_range(0, 31));
			default: return $urandom;
		endcase
	endfunction

	function automatic row_t mk_row(input logic op, input int lane, input int tap,
			input logic [31:0] kw, input logic [31:0] p0, input logic [31:0] p1,
			input logic fin, input bit typed, input logic signed [15:0] want);
		row_t x;
		x.req.opcode      = op;
		x.req.lane        = 4'(lane);
		x.req.tap         = 5'(tap);
		x.req.kernel_word = kw;
		x.req.plane_low   = p0;
		x.req.plane_high  = p1;
		x.req.final_req   = fin;
		x.typed           = typed;
		x.want            = want;
		return x;
	endfunction

	task automatic flag(input string what);
		errs++;
		if (errs <= 10)
			$display("tb_top: mismatch %0d: %s", errs, what);
	endtask

	// offers one request, waits for it to be taken, then books its sums
	task automatic send_request(input bcpa_pkg::item_t r, input bit typed,
			input logic signed [15:0] want);
		int n, pct;
		bcpa_pkg::result_t x;
		pct = (mode == 0) ? 21 : (mode == 1) ? 64 : 0;
		if ($urandom_range(0, 99) < pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < pct);
		end
		item       <= r;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		n = xnor_step(r);
		for (int j = 0; j < n; j++) begin
			x = run_buf[j];
			if (typed)
				x.sum = want;
			sums_due.push_back(x);
		end
		sent_n++;
	endtask

	// result side: check, then decide the stall for the next cycle
	always @(posedge clk) begin : rx
		bcpa_pkg::result_t due;
		int pct;
		if (arst_n && result_valid && !result_stall) begin
			results_n++;
			if (result.run_end)
				runs_n++;
			if (sums_due.size() == 0) begin
				flag($sformatf("unexpected result lane %0d sum %0d end %0d",
					result.out_lane, result.sum, result.run_end));
			end else begin
				due = sums_due.pop_front();
				if (result.out_lane !== due.out_lane || result.sum !== due.sum ||
						result.run_end !== due.run_end)
					flag($sformatf("lane/sum/end expected %0d/%0d/%0d, got %0d/%0d/%0d",
						due.out_lane, due.sum, due.run_end,
						result.out_lane, result.sum, result.run_end));
			end
		end
		pct = (mode == 0) ? 64 : (mode == 1) ? 21 : 0;
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (hold_req != hold_seen) begin
			hold_seen    = hold_req;
			hold_left    = 300;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < pct);
		end
	end

	initial begin
		bcpa_pkg::item_t r;
		row_t  tbl [16];
		int    base, span, len, t;
		bit    missing;

		for (int j = 0; j < 16; j++) lane_acc[j] = '0;
		for (int j = 0; j < 512; j++) kern_mem[j] = '0;

		tbl[0]  = mk_row(bcpa_pkg::OP_ACCUM, 0, 0, 32'h5A5A_A5A5, '0, '0, 1'b1, 1'b1, 16'sd0);
		tbl[1]  = mk_row(bcpa_pkg::OP_ACCUM, 15, 0, '1, '1, '1, 1'b1, 1'b1, 16'sd96);
		tbl[2]  = mk_row(bcpa_pkg::OP_ACCUM, 0, 1, '0, '0, '0, 1'b1, 1'b1, 16'sd0);
		tbl[3]  = mk_row(bcpa_pkg::OP_ACCUM, 0, 1, '0, '1, '1, 1'b1, 1'b1, -16'sd96);
		// a load ignores final_req and never emits
		tbl[4]  = mk_row(bcpa_pkg::OP_LOAD, 3, 2, 32'h0F0F_0F0F, '1, '1, 1'b1, 1'b0, 16'sd0);
		tbl[5]  = mk_row(bcpa_pkg::OP_LOAD, 15, 31, '1, '0, '0, 1'b0, 1'b0, 16'sd0);
		tbl[6]  = mk_row(bcpa_pkg::OP_ACCUM, 0, 0, '0, '1, '0, 1'b0, 1'b0, 16'sd0);
		tbl[7]  = mk_row(bcpa_pkg::OP_ACCUM, 0, 1, '0, '0, '1, 1'b1, 1'b1, -16'sd32);
		tbl[8]  = mk_row(bcpa_pkg::OP_ACCUM, 0, 0, '0, '0, '1, 1'b1, 1'b1, 16'sd64);
		tbl[9]  = mk_row(bcpa_pkg::OP_ACCUM, 0, 1, '0, '1, '0, 1'b1, 1'b1, -16'sd32);
		tbl[10] = mk_row(bcpa_pkg::OP_ACCUM, 0, 0, '0, 32'hAAAA_AAAA, 32'h5555_5555,
			1'b1, 1'b1, 16'sd48);
		tbl[11] = mk_row(bcpa_pkg::OP_ACCUM, 0, 1, '0, 32'hAAAA_AAAA, 32'h5555_5555,
			1'b1, 1'b1, -16'sd48);
		tbl[12] = mk_row(bcpa_pkg::OP_ACCUM, 0, 0, '0, '1, '1, 1'b0, 1'b0, 16'sd0);
		tbl[13] = mk_row(bcpa_pkg::OP_ACCUM, 0, 1, '0, '1, '1, 1'b1, 1'b1, 16'sd0);
		tbl[14] = mk_row(bcpa_pkg::OP_LOAD, 0, 1, '0, '0, '0, 1'b0, 1'b0, 16'sd0);
		tbl[15] = mk_row(bcpa_pkg::OP_ACCUM, 0, 1, '0, '1, '1, 1'b1, 1'b0, 16'sd0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// taps 0 and 1: all-zero and all-one kernels in every lane
		for (int tp = 0; tp < 2; tp++) begin
			for (int j = 0; j < 16; j++) begin
				r = '0;
				r.opcode      = bcpa_pkg::OP_LOAD;
				r.lane        = 4'(j);
				r.tap         = 5'(tp);
				r.kernel_word = tp ? '1 : '0;
				send_request(r, 1'b0, 16'sd0);
			end
		end
		for (int i = 0; i < 16; i++) send_request(tbl[i].req, tbl[i].typed, tbl[i].want);
		warm_taps = '{0, 1};

		// random pixels; the receiver holds off at the start so the pipe backs up
		base = sent_n;
		span = 310 - base;
		hold_req++;
		while (sent_n < 310) begin
			if (mode < 2 && sent_n - base >= span * (mode + 1) / 3) begin
				item_valid <= 1'b0;
				@(posedge clk);
				while (sums_due.size() != 0) @(posedge clk);
				mode++;
			end
			if ($urandom_range(0, 99) < 20) begin
				r = '0;
				r.opcode      = bcpa_pkg::OP_LOAD;
				r.lane        = 4'($urandom_range(0, 15));
				r.tap         = 5'($urandom_range(0, 31));
				r.kernel_word = pick_word();
				r.plane_low   = $urandom;
				r.plane_high  = $urandom;
				r.final_req   = 1'($urandom_range(0, 1));
				send_request(r, 1'b0, 16'sd0);
			end else begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 99) < 85) begin
						t = warm_taps[$urandom_range(0, warm_taps.size() - 1)];
					end else begin
						t = $urandom_range(0, 31);
						missing = 1'b0;
						// every lane of the tap must hold a word before it is read
						for (int j = 0; j < 16; j++) begin
							if (!kern_set[j * 32 + t]) begin
								missing = 1'b1;
								r = '0;
								r.opcode      = bcpa_pkg::OP_LOAD;
								r.lane        = 4'(j);
								r.tap         = 5'(t);
								r.kernel_word = pick_word();
								r.plane_low   = $urandom;
								r.final_req   = 1'($urandom_range(0, 1));
								send_request(r, 1'b0, 16'sd0);
							end
						end
						if (missing)
							warm_taps.push_back(t);
					end
					r = '0;
					r.opcode      = bcpa_pkg::OP_ACCUM;
					r.lane        = 4'($urandom_range(0, 15));
					r.tap         = 5'(t);
					r.kernel_word = $urandom;
					r.plane_low   = pick_word();
					r.plane_high  = pick_word();
					r.final_req   = (i == len - 1);
					send_request(r, 1'b0, 16'sd0);
				end
			end
		end

		item_valid <= 1'b0;
		@(posedge clk);
		while (sums_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sums_due.size() != 0)
			flag($sformatf("%0d sums never arrived", sums_due.size()));

		$display("tb_top: %0d requests taken, %0d sums checked over %0d runs",
			sent_n, results_n, runs_n);
		$display("tb_top: covered extremes, loads with final set, hold-off, three idle mixes");
		if (errs == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
